// File: hw/rtl/csp_pkg.sv
// Shared types and constants for the convex support point block.
// No dependencies; imported by csp_norm, convex_support_point, csp_checker and the testbench.
package csp_pkg;

  // shape kinds held in the shape_kind register
  localparam logic [2:0] KIND_TRI   = 3'd0;
  localparam logic [2:0] KIND_THICK = 3'd1;
  localparam logic [2:0] KIND_BOX   = 3'd2;
  localparam logic [2:0] KIND_CAPS  = 3'd3;
  localparam logic [2:0] KIND_SPH   = 3'd4;
  localparam logic [2:0] KIND_CYL   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_SHAPE_KIND  = 3'd0;
  localparam logic [2:0] REG_MARGIN      = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_HALF_LENGTH = 3'd3;
  localparam logic [2:0] REG_BOX_HALF_X  = 3'd4;
  localparam logic [2:0] REG_BOX_HALF_Y  = 3'd5;
  localparam logic [2:0] REG_BOX_HALF_Z  = 3'd6;

  localparam logic [16:0] MARGIN_RESET = 17'd1638;

  localparam logic [2:0] TRI_LAST   = 3'd2;
  localparam logic [2:0] THICK_LAST = 3'd5;

  // item kinds
  localparam logic ITEM_LOAD  = 1'b0;
  localparam logic ITEM_QUERY = 1'b1;

  localparam int unsigned CNT_W = 5;

  typedef struct packed {
    logic               kind;
    logic [2:0]         vertex_index;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_item_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [2:0] neg;
  } norm_stat_t;

endpackage

// File: hw/rtl/convex_support_point.sv
// Top level of the GJK support point unit with collision margin, Q16.16.
// Depends on csp_pkg and csp_norm.
//
// Input channel in_valid_i / in_stall_o carries in_item_t; a transfer happens
// when valid is high and stall is low. A load item writes one vertex slot and
// produces no result; the block is ready again on the next cycle. A query
// item produces one out_item_t on out_valid_o / out_stall_i.
// Box and unused kinds go from the input straight to the output register.
// Other kinds run the axis normalizer (magnitude scaling, squares, a serial
// square root and a restoring divide per component), then products on the
// shared multiplier: the vertex dot products for the triangle kinds plus the
// margin terms. A cylinder query whose axis is not along x runs the normalizer
// a second time, on y and z, for the radius terms. The normalizer's serial
// square root and divide set the rate; one query is in flight at a time.
// in_stall_o is high while a query is being worked on. The result sits in an
// output register; a load may be taken while it waits, and a new result
// waits until the old one is transferred. Reset clears the vertex store and
// sets the registers to their reset values (margin 1638).
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
module convex_support_point #(
  parameter int MAX_VERTICES = 6,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csp_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);
  import csp_pkg::*;

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW = 35;
  localparam int DW = 68;
  localparam logic [63:0] THR =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM_A, ST_CYL, ST_NORM_YZ, ST_DOT, ST_PICK, ST_SCALE, ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [2:0]       kind_q;
  logic [16:0]      margin_q;
  logic [30:0]      radius_q, half_q;
  logic [2:0][30:0] box_q;

  logic [2:0][31:0] vstore_q [MAX_VERTICES];

  logic [2:0][31:0]        a_q;
  logic [2:0][FRAC_BITS:0] nq_q;
  logic [2:0]              nneg_q;
  logic                    ph_q, pass_q, norm_start_q;
  logic [1:0]              comp_q;
  logic [2:0]              vidx_q, bidx_q;
  logic signed [65:0]      prod_q;
  logic signed [DW-1:0]    dot_q, best_q;
  logic signed [PW-1:0]    p_q [3];
  logic                    out_valid_q;
  out_item_t               out_q;

  // normalizer
  logic [2:0][31:0]        norm_vec;
  logic [2:0][FRAC_BITS:0] norm_mag;
  norm_stat_t              norm_stat;

  logic [2:0]              rd_idx;
  logic [2:0][31:0]        vtx_rd;
  logic [2:0][31:0]        ax_in;
  logic signed [32:0]      op_a, op_b;
  logic signed [DW-1:0]    acc_new;
  logic                    upd, last_v, ax_pos, in_acc, out_free;
  logic [31:0]             l0;
  logic [FRAC_BITS:0]      qsel;
  logic                    negsel;
  logic signed [PW-1:0]    tsc, half_s, halfm_s;
  logic signed [PW-1:0]    p_out [3];

  csp_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start_q),
    .vec_i  (norm_vec),
    .mag_o  (norm_mag),
    .stat_o (norm_stat)
  );

  always_comb begin
    norm_vec = (state_q == ST_NORM_YZ) ? {a_q[2], a_q[1], 32'd0} : a_q;
    rd_idx   = (state_q == ST_PICK) ? bidx_q : vidx_q;
    vtx_rd   = '0;
    if ({1'b0, rd_idx} < 4'(MAX_VERTICES)) vtx_rd = vstore_q[rd_idx[IW-1:0]];
    ax_in    = {in_item_i.axis_z, in_item_i.axis_y, in_item_i.axis_x};
    ax_pos   = !a_q[0][31] && (a_q[0] != 32'd0);
    half_s   = ax_pos ? PW'(half_q) : -PW'(half_q);
    halfm_s  = ax_pos ? (PW'(half_q) + PW'(margin_q)) : -(PW'(half_q) + PW'(margin_q));
    l0       = (kind_q == KIND_CAPS || kind_q == KIND_SPH) ?
               (32'(radius_q) + 32'(margin_q)) : 32'(margin_q);
    qsel     = pass_q ? norm_mag[comp_q] : nq_q[comp_q];
    negsel   = pass_q ? norm_stat.neg[comp_q] : nneg_q[comp_q];
    op_a     = '0;
    op_b     = '0;
    unique case (state_q)
      ST_DOT: begin
        op_a = 33'(signed'(vtx_rd[comp_q]));
        op_b = 33'(signed'(a_q[comp_q]));
      end
      ST_CYL: begin
        op_a = 33'(signed'(a_q[comp_q]));
        op_b = 33'(signed'(a_q[comp_q]));
      end
      ST_SCALE: begin
        op_a = signed'(33'(qsel));
        op_b = pass_q ? signed'(33'(radius_q)) : signed'(33'(l0));
      end
      default: ;
    endcase
    acc_new = (comp_q == 2'd0 && state_q == ST_DOT) ? DW'(prod_q) : dot_q + DW'(prod_q);
    upd     = (vidx_q == 3'd0) ||
              ((kind_q == KIND_TRI) ? (acc_new >= best_q) : (acc_new > best_q));
    last_v  = (kind_q == KIND_TRI) ? (vidx_q == TRI_LAST) : (vidx_q == THICK_LAST);
    tsc     = PW'(prod_q >>> FRAC_BITS);
    if (negsel) tsc = -tsc;
    in_acc   = in_valid_i && !in_stall_o;
    out_free = !out_valid_q || !out_stall_i;
    for (int k = 0; k < 3; k++) begin
      if (p_q[k] > PW'(32'sh7FFF_FFFF)) p_out[k] = PW'(32'sh7FFF_FFFF);
      else if (p_q[k] < -PW'(33'sh0_8000_0000)) p_out[k] = -PW'(33'sh0_8000_0000);
      else p_out[k] = p_q[k];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= KIND_TRI;
      margin_q     <= MARGIN_RESET;
      radius_q     <= '0;
      half_q       <= '0;
      box_q        <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) vstore_q[i] <= '0;
      norm_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ph_q         <= 1'b0;
      pass_q       <= 1'b0;
      comp_q       <= '0;
      vidx_q       <= '0;
      bidx_q       <= '0;
    end else begin
      norm_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SHAPE_KIND:  kind_q   <= cfg_data_i[2:0];
          REG_MARGIN:      margin_q <= cfg_data_i[16:0];
          REG_RADIUS:      radius_q <= cfg_data_i;
          REG_HALF_LENGTH: half_q   <= cfg_data_i;
          REG_BOX_HALF_X:  box_q[0] <= cfg_data_i;
          REG_BOX_HALF_Y:  box_q[1] <= cfg_data_i;
          REG_BOX_HALF_Z:  box_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_DOT || state_q == ST_CYL || state_q == ST_SCALE) begin
        ph_q <= !ph_q;
        if (!ph_q) prod_q <= op_a * op_b;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_item_i.kind == ITEM_LOAD) begin
              if ({1'b0, in_item_i.vertex_index} < 4'(MAX_VERTICES)) begin
                vstore_q[in_item_i.vertex_index[IW-1:0]] <=
                  {in_item_i.vertex_z, in_item_i.vertex_y, in_item_i.vertex_x};
              end
            end else begin
              a_q <= {in_item_i.axis_z, in_item_i.axis_y, in_item_i.axis_x};
              ph_q   <= 1'b0;
              pass_q <= 1'b0;
              comp_q <= '0;
              vidx_q <= '0;
              if (kind_q == KIND_BOX) begin
                // zero component counts as negative
                for (int k = 0; k < 3; k++) begin
                  p_q[k] <= (!ax_in[k][31] && ax_in[k] != 32'd0) ?
                            (PW'(box_q[k]) + PW'(margin_q)) :
                            -(PW'(box_q[k]) + PW'(margin_q));
                end
                state_q <= ST_OUT;
              end else if (kind_q > KIND_CYL) begin
                for (int k = 0; k < 3; k++) p_q[k] <= '0;
                state_q <= ST_OUT;
              end else begin
                norm_start_q <= 1'b1;
                state_q      <= ST_NORM_A;
              end
            end
          end
        end
        ST_NORM_A: begin
          if (norm_stat.done) begin
            nq_q   <= norm_mag;
            nneg_q <= norm_stat.neg;
            if (kind_q == KIND_CYL) begin
              comp_q  <= 2'd1;
              state_q <= ST_CYL;
            end else if (kind_q == KIND_TRI || kind_q == KIND_THICK) begin
              state_q <= ST_DOT;
            end else begin
              p_q[0]  <= (kind_q == KIND_CAPS) ? half_s : '0;
              p_q[1]  <= '0;
              p_q[2]  <= '0;
              state_q <= ST_SCALE;
            end
          end
        end
        ST_CYL: begin
          if (ph_q) begin
            dot_q <= acc_new;
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              p_q[1] <= '0;
              p_q[2] <= '0;
              if (acc_new < DW'(THR)) begin
                p_q[0]  <= halfm_s;
                state_q <= ST_OUT;
              end else begin
                p_q[0]       <= half_s;
                norm_start_q <= 1'b1;
                state_q      <= ST_NORM_YZ;
              end
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end else if (comp_q == 2'd1) begin
            dot_q <= '0;
          end
        end
        ST_NORM_YZ: begin
          if (norm_stat.done) state_q <= ST_SCALE;
        end
        ST_DOT: begin
          if (ph_q) begin
            dot_q <= acc_new;
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (upd) begin
                best_q <= acc_new;
                bidx_q <= vidx_q;
              end
              if (last_v) state_q <= ST_PICK;
              else vidx_q <= vidx_q + 3'd1;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        ST_PICK: begin
          for (int k = 0; k < 3; k++) p_q[k] <= PW'(signed'(vtx_rd[k]));
          comp_q  <= '0;
          ph_q    <= 1'b0;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          if (ph_q) begin
            p_q[comp_q] <= p_q[comp_q] + tsc;
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (kind_q == KIND_CYL && !pass_q) pass_q <= 1'b1;
              else state_q <= ST_OUT;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_q.point_x <= p_out[0][31:0];
            out_q.point_y <= p_out[1][31:0];
            out_q.point_z <= p_out[2][31:0];
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.kind == ITEM_QUERY) |=> in_stall_o)
    else $error("query transfer did not make the block busy");

  a_norm_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_stat.busy |-> (state_q == ST_NORM_A || state_q == ST_NORM_YZ))
    else $error("normalizer running outside a normalize state");

  a_second_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE && pass_q) |-> (kind_q == KIND_CYL))
    else $error("radius pass outside cylinder");

endmodule

// File: hw/rtl/csp_norm.sv
// Iterative axis normalizer: magnitude scaling, bit-serial square root and
// restoring divide, one step per cycle. Depends on csp_pkg.
module csp_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2:0][31:0]       vec_i,
  output logic [2:0][FRAC_BITS:0] mag_o,
  output csp_pkg::norm_stat_t    stat_o
);
  import csp_pkg::*;

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV} nstate_e;

  nstate_e               state_q;
  logic [2:0][31:0]      m_q;
  logic [2:0]            neg_q;
  logic [63:0]           s_q, prod_q, r_q, v_q, b_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [1:0]            k_q;
  logic [33:0]           rem_q;
  logic [FRAC_BITS:0]    qacc_q;
  logic [2:0][FRAC_BITS:0] q_q;
  logic                  done_q;

  logic [2:0][31:0] m_in;
  logic [31:0]      mx, mx_in;
  logic [1:0]       sq_idx;
  logic [63:0]      rb;
  logic             qbit;
  logic [33:0]      rem_sub;
  logic [FRAC_BITS:0] qnext;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_in[k] = vec_i[k][31] ? (~vec_i[k] + 32'd1) : vec_i[k];
    end
    mx_in = m_in[0];
    if (m_in[1] > mx_in) mx_in = m_in[1];
    if (m_in[2] > mx_in) mx_in = m_in[2];
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    sq_idx  = (cnt_q < CNT_W'(3)) ? cnt_q[1:0] : 2'd0;
    rb      = r_q + b_q;
    qbit    = (rem_q >= {2'b00, r_q[31:0]});
    rem_sub = qbit ? (rem_q - {2'b00, r_q[31:0]}) : rem_q;
    qnext   = {qacc_q[FRAC_BITS-1:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      neg_q   <= '0;
      q_q     <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        N_IDLE: begin
          if (start_i) begin
            m_q <= m_in;
            neg_q <= {vec_i[2][31], vec_i[1][31], vec_i[0][31]};
            if (mx_in == 32'd0) begin
              q_q    <= '0;
              done_q <= 1'b1;
            end else begin
              state_q <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (mx < 32'h4000_0000) begin
            for (int k = 0; k < 3; k++) begin
              m_q[k] <= (mx < 32'h0040_0000) ? (m_q[k] << 8) : (m_q[k] << 1);
            end
          end else begin
            state_q <= N_SQ;
            cnt_q   <= '0;
            s_q     <= '0;
          end
        end
        N_SQ: begin
          // square issued one cycle, summed the next
          if (cnt_q != CNT_W'(0)) s_q <= s_q + prod_q;
          prod_q <= 64'(m_q[sq_idx]) * 64'(m_q[sq_idx]);
          if (cnt_q == CNT_W'(3)) begin
            state_q <= N_SQRT;
            cnt_q   <= '0;
            v_q     <= s_q + prod_q;
            r_q     <= '0;
            b_q     <= 64'h4000_0000_0000_0000;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        N_SQRT: begin
          if (v_q >= rb) begin
            v_q <= v_q - rb;
            r_q <= (r_q >> 1) + b_q;
          end else begin
            r_q <= r_q >> 1;
          end
          b_q <= b_q >> 2;
          if (cnt_q == CNT_W'(31)) begin
            state_q <= N_DIV;
            cnt_q   <= '0;
            k_q     <= '0;
            rem_q   <= {2'b00, m_q[0]};
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        N_DIV: begin
          qacc_q <= qnext;
          rem_q  <= rem_sub << 1;
          if (cnt_q == CNT_W'(FRAC_BITS)) begin
            q_q[k_q] <= qnext;
            cnt_q    <= '0;
            if (k_q == 2'd2) begin
              state_q <= N_IDLE;
              done_q  <= 1'b1;
            end else begin
              k_q   <= k_q + 2'd1;
              rem_q <= {2'b00, m_q[k_q + 2'd1]};
            end
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign mag_o       = q_q;
  assign stat_o.busy = (state_q != N_IDLE);
  assign stat_o.done = done_q;
  assign stat_o.neg  = neg_q;

endmodule

// File: bench/csp_checker.sv
// Checker for the convex support point block: watches both channels,
// predicts each query's support point and compares. Depends on csp_pkg.
`timescale 1ns / 100ps
module csp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  csp_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  csp_pkg::out_item_t out_item_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 points_seen_o
);
  import csp_pkg::*;

  localparam int NVERT = 6;
  localparam int FB    = 16;

  logic signed [31:0] verts [NVERT][3];
  logic [2:0]  shape_q;
  logic [63:0] margin_q, radius_q, half_len_q;
  logic [63:0] box_q [3];
  out_item_t   point_q [$];

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed_of(input bit neg, input logic [63:0] m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // direction scaled to unit length, Q16.16
  function automatic void normalize(input longint a [3], output longint u [3]);
    logic [63:0] m [3];
    logic [63:0] mx, s, len;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = mag(a[k]);
      if (m[k] > mx) mx = m[k];
    end
    if (mx == 0) begin
      for (int k = 0; k < 3; k++) u[k] = 0;
      return;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) m[k] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = floor_sqrt(s);
    for (int k = 0; k < 3; k++) u[k] = signed_of(a[k] < 0, (m[k] << FB) / len);
  endfunction

  function automatic longint scaled(input longint n, input logic [63:0] len);
    return signed_of(n < 0, (mag(n) * len) >> FB);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact 3-term dot product, 66 bits is plenty
  function automatic logic signed [71:0] vdot(input int i, input longint a [3]);
    logic signed [71:0] acc;
    acc = 0;
    for (int k = 0; k < 3; k++) acc += 72'(verts[i][k]) * 72'(a[k]);
    return acc;
  endfunction

  function automatic out_item_t support_point(input in_item_t it);
    longint a [3], n [3], p [3], yz [3], u [3];
    logic signed [71:0] d [NVERT];
    logic [63:0] s, thr, h;
    int best, cnt;
    out_item_t r;
    a[0] = it.axis_x; a[1] = it.axis_y; a[2] = it.axis_z;
    for (int k = 0; k < 3; k++) p[k] = 0;
    normalize(a, n);
    case (shape_q)
      KIND_TRI, KIND_THICK: begin
        cnt = (shape_q == KIND_TRI) ? 3 : 6;
        for (int i = 0; i < cnt; i++) d[i] = vdot(i, a);
        if (shape_q == KIND_TRI) begin
          // ties go to the later vertex
          if (d[0] > d[1] && d[0] > d[2]) best = 0;
          else if (d[1] > d[2]) best = 1;
          else best = 2;
        end else begin
          best = 0;
          for (int i = 1; i < 6; i++) if (d[i] > d[best]) best = i;
        end
        for (int k = 0; k < 3; k++) p[k] = verts[best][k] + scaled(n[k], margin_q);
      end
      KIND_BOX: begin
        for (int k = 0; k < 3; k++) begin
          h = box_q[k] + margin_q;
          p[k] = a[k] > 0 ? longint'(h) : -longint'(h);
        end
      end
      KIND_CAPS, KIND_SPH: begin
        for (int k = 0; k < 3; k++) p[k] = scaled(n[k], radius_q + margin_q);
        if (shape_q == KIND_CAPS)
          p[0] += a[0] > 0 ? longint'(half_len_q) : -longint'(half_len_q);
      end
      KIND_CYL: begin
        s = mag(a[1]) * mag(a[1]) + mag(a[2]) * mag(a[2]);
        thr = ((64'd1 << (2 * FB)) + 500000) / 1000000;
        if (s < thr) begin
          // axis along x: cap point
          h = half_len_q + margin_q;
          p[0] = a[0] > 0 ? longint'(h) : -longint'(h);
        end else begin
          yz[0] = 0; yz[1] = a[1]; yz[2] = a[2];
          normalize(yz, u);
          for (int k = 0; k < 3; k++) p[k] = scaled(u[k], radius_q) + scaled(n[k], margin_q);
          p[0] += a[0] > 0 ? longint'(half_len_q) : -longint'(half_len_q);
        end
      end
      default: ;
    endcase
    r.point_x = clamp32(p[0]);
    r.point_y = clamp32(p[1]);
    r.point_z = clamp32(p[2]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t w;
    if (!rst_ni) begin
      for (int i = 0; i < NVERT; i++) for (int k = 0; k < 3; k++) verts[i][k] = 0;
      shape_q = KIND_TRI;
      margin_q = MARGIN_RESET;
      radius_q = 0;
      half_len_q = 0;
      for (int k = 0; k < 3; k++) box_q[k] = 0;
      point_q.delete();
      fail_count_o = 0;
      points_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        points_seen_o++;
        if (point_q.size() == 0) begin
          report_mismatch("unexpected point", 0, 0);
        end else begin
          w = point_q.pop_front();
          if (out_item_i.point_x !== w.point_x) report_mismatch("x", out_item_i.point_x, w.point_x);
          if (out_item_i.point_y !== w.point_y) report_mismatch("y", out_item_i.point_y, w.point_y);
          if (out_item_i.point_z !== w.point_z) report_mismatch("z", out_item_i.point_z, w.point_z);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SHAPE_KIND:  shape_q = cfg_data_i[2:0];
          REG_MARGIN:      margin_q = cfg_data_i[16:0];
          REG_RADIUS:      radius_q = cfg_data_i;
          REG_HALF_LENGTH: half_len_q = cfg_data_i;
          REG_BOX_HALF_X:  box_q[0] = cfg_data_i;
          REG_BOX_HALF_Y:  box_q[1] = cfg_data_i;
          REG_BOX_HALF_Z:  box_q[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.kind == ITEM_LOAD) begin
          if (in_item_i.vertex_index < NVERT) begin
            verts[in_item_i.vertex_index][0] = in_item_i.vertex_x;
            verts[in_item_i.vertex_index][1] = in_item_i.vertex_y;
            verts[in_item_i.vertex_index][2] = in_item_i.vertex_z;
          end
        end else begin
          point_q.push_back(support_point(in_item_i));
        end
      end
    end
  end

  assign pending_o = point_q.size();
endmodule

// File: bench/convex_support_point_tb.sv
// Testbench top for convex_support_point: drives loads, queries and register
// writes, stalls the output, and reports the verdict. Depends on csp_pkg, csp_checker.
`timescale 1ns / 100ps
module convex_support_point_tb;
  import csp_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_item;
  logic       cfg_we = 0;
  logic [2:0] cfg_idx = '0;
  logic [30:0] cfg_data = '0;
  int fail_count, pending, points_seen;
  longint cycles = 0;
  int stall_mode = 0;
  int queries_sent = 0;

  always #10 clk_i = ~clk_i;

  convex_support_point u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  csp_checker u_check (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .points_seen_o(points_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern, mode switched by the stimulus
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send(input in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (it.kind == ITEM_QUERY) queries_sent++;
  endtask

  task automatic go_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 600000)) - 300000);
      3: return 32'($urandom_range(0, 15)) - 32'd7;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t load_item(input int idx, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    in_item_t it;
    it = '0;
    it.kind = ITEM_LOAD;
    it.vertex_index = 3'(idx);
    it.vertex_x = x; it.vertex_y = y; it.vertex_z = z;
    it.axis_x = $urandom; it.axis_y = $urandom; it.axis_z = $urandom;
    return it;
  endfunction

  function automatic in_item_t query_item(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
    in_item_t it;
    it.kind = ITEM_QUERY;
    it.vertex_index = 3'($urandom);
    it.vertex_x = $urandom; it.vertex_y = $urandom; it.vertex_z = $urandom;
    it.axis_x = x; it.axis_y = y; it.axis_z = z;
    return it;
  endfunction

  function automatic in_item_t random_item();
    if ($urandom_range(0, 3) == 0)
      return load_item($urandom_range(0, 7), rand_coord(), rand_coord(), rand_coord());
    // small y/z sometimes to hit the cylinder cap
    if ($urandom_range(0, 7) == 0)
      return query_item(rand_coord(), $urandom_range(0, 2), $urandom_range(0, 2));
    return query_item(rand_coord(), rand_coord(), rand_coord());
  endfunction

  initial begin
    int burst;
    logic [30:0] cfg_set [7];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset margin, zeroed store, then extremes and ties
    send(query_item(32'h00010000, 0, 0));
    send(load_item(0, 32'h00010000, 0, 0));
    send(load_item(1, 32'h00010000, 0, 0));
    send(load_item(2, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send(load_item(7, 32'h12345678, 32'h1, 32'h2));
    send(query_item(32'h00010000, 0, 0));
    send(query_item(0, 0, 0));
    send(query_item(32'h80000000, 32'h80000000, 32'h80000000));
    send(query_item(32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send(load_item(3, 32'h00010000, 0, 0));
    send(load_item(4, 32'h00020000, 5, 5));
    send(load_item(5, 32'h00020000, 5, 5));
    drain();
    write_reg(REG_SHAPE_KIND, 31'(KIND_THICK));
    send(query_item(32'h00010000, 0, 0));
    send(query_item(32'hffff0000, 0, 0));
    drain();
    write_reg(REG_SHAPE_KIND, 31'(KIND_CYL));
    write_reg(REG_RADIUS, 31'h7fffffff);
    write_reg(REG_HALF_LENGTH, 31'h7fffffff);
    write_reg(REG_MARGIN, 31'h10000);
    send(query_item(32'h00010000, 1, 1));
    send(query_item(0, 0, 0));
    send(query_item(32'h00010000, 32'h00010000, 0));
    drain();

    // random phases over each shape, extreme and typical settings
    for (int ph = 0; ph < 16; ph++) begin
      cfg_set[REG_SHAPE_KIND] = 31'((ph < 14) ? ph % 6 : 6 + ph % 2);
      cfg_set[REG_MARGIN] = (ph % 4 == 0) ? 31'd0 : (ph % 4 == 1) ? 31'h10000
                            : 31'($urandom_range(0, 65536));
      for (int r = REG_RADIUS; r <= REG_BOX_HALF_Z; r++)
        cfg_set[r] = (ph % 3 == 0) ? 31'h7fffffff : (ph % 3 == 1) ? 31'd0
                     : 31'($urandom_range(0, 32'h00200000));
      for (int r = 0; r < 7; r++) write_reg(3'(r), cfg_set[r]);
      stall_mode = ph % 3;
      for (int n = 0; n < 88; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n < 88; b++, n++) send(random_item());
        if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 6));
        // hold off until all points are back
        if (n % 40 == 0) drain();
      end
      drain();
    end

    stall_mode = 0;
    drain();
    $display("sent %0d queries over all six shapes and unused kinds, %0d points checked",
             queries_sent, points_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
